// ----- sv/sha_pkg.sv -----
// sha_pkg: shared types, constants and round functions for the sha-256 digest core
// depends on nothing
`timescale 1ns / 1ps
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    // queue entry from the intake side: one byte and/or an end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

endpackage

// ----- sv/sha_intake.sv -----
// sha_intake: front end, takes input words into a short queue
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_intake #(
    parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sha_pkg::in_word_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output sha_pkg::cmd_t     q_data
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    sha_pkg::cmd_t      mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]      wr_reg, rd_reg;
    logic [AW:0]        cnt_reg;
    logic               push, pop;

    assign s_ready = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // items with neither bit set are dropped here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push && (s_data.byte_present || s_data.end_of_message)) begin
                mem_reg[wr_reg] <= '{s_data.data_byte, s_data.byte_present,
                                     s_data.end_of_message};
                wr_reg <= (wr_reg == AW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) rd_reg <= (rd_reg == AW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg
                + (AW+1)'(push && (s_data.byte_present || s_data.end_of_message))
                - (AW+1)'(pop);
        end
    end
endmodule

// ----- sv/sha_engine.sv -----
// sha_engine: back end, block assembly, padding, 64-round compression, digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  sha_pkg::cmd_t      q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sha_pkg::out_word_t m_data
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PAD  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_COMP = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    h_reg [8];
    logic [31:0]    blk_reg [16];
    logic [31:0]    w_reg [16];
    logic [31:0]    v_reg [8];
    logic [63:0]    cnt_reg;
    logic [5:0]     round_reg;
    logic           fin_reg;        // pad byte still to be placed after this compression
    logic           tail_reg;       // a length-only block still to be compressed
    logic           lenblk_reg;     // block in flight carries the bit length
    logic [2:0]     oidx_reg;

    logic [31:0] w15, w2, s0, s1, t1, t2, a, e;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = '{h_reg[oidx_reg], oidx_reg, oidx_reg == 3'd7};

    always_comb begin
        a   = v_reg[0];
        e   = v_reg[4];
        // w window is a shift line, w_reg[0] is the current word
        w15 = w_reg[1];
        w2  = w_reg[14];
        s0  = sha_pkg::ror32(w15, 7) ^ sha_pkg::ror32(w15, 18) ^ (w15 >> 3);
        s1  = sha_pkg::ror32(w2, 17) ^ sha_pkg::ror32(w2, 19) ^ (w2 >> 10);
        t1  = v_reg[7] + (sha_pkg::ror32(e, 6) ^ sha_pkg::ror32(e, 11) ^ sha_pkg::ror32(e, 25))
            + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::round_k(round_reg) + w_reg[0];
        t2  = (sha_pkg::ror32(a, 2) ^ sha_pkg::ror32(a, 13) ^ sha_pkg::ror32(a, 22))
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) begin
                if (q_data.byte_present && cnt_reg[5:0] == 6'd63) state_next = ST_LOAD;
                else if (q_data.end_of_message) state_next = ST_PAD;
            end
            ST_PAD:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_COMP;
            ST_COMP: if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD: begin
                if (lenblk_reg) state_next = ST_OUT;
                else if (fin_reg) state_next = ST_PAD;
                else if (tail_reg) state_next = ST_LOAD;
                else state_next = ST_IDLE;
            end
            ST_OUT:  if (m_ready && oidx_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            round_reg  <= '0;
            fin_reg    <= 1'b0;
            tail_reg   <= 1'b0;
            lenblk_reg <= 1'b0;
            oidx_reg   <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::INIT_H[255-32*i -: 32];
            for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: if (q_valid) begin
                    if (q_data.byte_present) begin
                        blk_reg[cnt_reg[5:2]][{~cnt_reg[1:0], 3'b000} +: 8] <= q_data.data_byte;
                        cnt_reg <= cnt_reg + 64'd1;
                    end
                    fin_reg <= q_data.end_of_message;
                end
                ST_PAD: begin
                    // bytes past the pad are already zero, the buffer is cleared per block
                    blk_reg[cnt_reg[5:2]][{~cnt_reg[1:0], 3'b000} +: 8] <= sha_pkg::PAD_BYTE;
                    fin_reg <= 1'b0;
                    if (cnt_reg[5:0] < 6'd56) lenblk_reg <= 1'b1;
                    else tail_reg <= 1'b1;
                end
                ST_LOAD: begin
                    for (int i = 0; i < 14; i++) w_reg[i] <= blk_reg[i];
                    w_reg[14] <= lenblk_reg ? cnt_reg[60:29] : blk_reg[14];
                    w_reg[15] <= lenblk_reg ? {cnt_reg[28:0], 3'b000} : blk_reg[15];
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                    round_reg <= '0;
                end
                ST_COMP: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_reg[0] + s0 + w_reg[9] + s1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
                    oidx_reg <= '0;
                    if (!lenblk_reg && !fin_reg && tail_reg) begin
                        lenblk_reg <= 1'b1;
                        tail_reg   <= 1'b0;
                    end
                end
                ST_OUT: if (m_ready) begin
                    oidx_reg <= oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= sha_pkg::INIT_H[255-32*i -: 32];
                        cnt_reg    <= '0;
                        lenblk_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- sv/sha256_digest_core.sv -----
// sha256_digest_core: top level of the sha-256 digest block
// depends on sha_pkg, sha_intake, sha_engine
`timescale 1ns / 1ps
// takes a message one byte per word and, on the word marked end_of_message,
// emits the eight 32-bit digest words, most significant first, then starts over
// from the initial hash. a front queue takes words while the back end works;
// the back end takes one byte word per cycle while idle, and each full block
// then runs a schedule load, 64 rounds on the single round unit and a hash
// update, during which no byte word is taken; the end word costs a pad step
// plus one or two blocks, then the eight digest words leave at one per
// cycle while the receiver is ready; words with neither bit set are dropped
module sha256_digest_core #(
    parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sha_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sha_pkg::out_word_t m_data
);
    logic          q_valid, q_ready;
    sha_pkg::cmd_t q_data;

    // front end: queue of words
    sha_intake #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_intake (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    // back end: block buffer, padding, round unit and digest output
    sha_engine u_engine (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule
